>>> rtl/dbscan_point_clustering_defines.svh
// ----------------------------------------------------------------------------
// dbscan_point_clustering_defines
// Assertion macros for the point clustering block.
// ----------------------------------------------------------------------------
`ifndef DBSCAN_POINT_CLUSTERING_DEFINES_SVH
`define DBSCAN_POINT_CLUSTERING_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define DBS_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define DBS_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`endif

>>> rtl/dbs_pkg.sv
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared widths and types of the point clustering block.
// ----------------------------------------------------------------------------
package dbs_pkg;
   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int LBL_BITS   = 7;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIFF_BITS + 1;

   localparam logic [1:0] REG_RADIUS     = 2'd0;
   localparam logic [1:0] REG_MIN_POINTS = 2'd1;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN_P,
      ST_CNT,
      ST_CNT_WAIT,
      ST_ENQ,
      ST_ENQ_WAIT,
      ST_POP,
      ST_POP_WAIT,
      ST_EMIT,
      ST_EMIT_WAIT,
      ST_CLEAR
   } state_type;

   // Memory access request from the sequencer to the point store.
   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      logic [COORD_BITS-1:0] wr_x;
      logic [COORD_BITS-1:0] wr_y;
      logic [IDX_BITS-1:0] rd_addr;
   } pt_req_type;
endpackage

>>> rtl/dbs_point_store.sv
// ----------------------------------------------------------------------------
// dbs_point_store
// Coordinate memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dbs_point_store (
   input  logic                             clock,
   input  dbs_pkg::pt_req_type              req,
   output logic [dbs_pkg::COORD_BITS-1:0]   rd_x,
   output logic [dbs_pkg::COORD_BITS-1:0]   rd_y
);
   logic [2*dbs_pkg::COORD_BITS-1:0] mem [dbs_pkg::MAX_POINTS];
   logic [2*dbs_pkg::COORD_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= {req.wr_x, req.wr_y};
      end
      rd_ff <= mem[req.rd_addr];
   end

   assign rd_x = rd_ff[2*dbs_pkg::COORD_BITS-1:dbs_pkg::COORD_BITS];
   assign rd_y = rd_ff[dbs_pkg::COORD_BITS-1:0];
endmodule

>>> rtl/dbs_dist.sv
// ----------------------------------------------------------------------------
// dbs_dist
// Two-stage squared distance test against the squared radius.
// ----------------------------------------------------------------------------
module dbs_dist (
   input  logic                             clock,
   input  logic [dbs_pkg::COORD_BITS-1:0]   ax,
   input  logic [dbs_pkg::COORD_BITS-1:0]   ay,
   input  logic [dbs_pkg::COORD_BITS-1:0]   bx,
   input  logic [dbs_pkg::COORD_BITS-1:0]   by,
   input  logic [15:0]                      radius,
   output logic                             near
);
   localparam int DB = dbs_pkg::DIFF_BITS;
   logic signed [DB-1:0] dx, dy;
   logic [DB-1:0] adx, ady;
   logic [2*DB-1:0] sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [31:0] rr_ff, rr_in;
   logic [dbs_pkg::SQ_BITS-1:0] sum;

   always_comb begin
      dx = DB'($signed(ax)) - DB'($signed(bx));
      dy = DB'($signed(ay)) - DB'($signed(by));
      adx = dx[DB-1] ? DB'(-dx) : DB'(dx);
      ady = dy[DB-1] ? DB'(-dy) : DB'(dy);
      sqx_in = adx * adx;
      sqy_in = ady * ady;
      rr_in = radius * radius;
      sum = dbs_pkg::SQ_BITS'(sqx_ff) + dbs_pkg::SQ_BITS'(sqy_ff);
      near = (dbs_pkg::SQ_BITS + 32)'(sum) <= (dbs_pkg::SQ_BITS + 32)'(rr_ff);
   end

   always_ff @(posedge clock) begin
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      rr_ff <= rr_in;
   end
endmodule

>>> rtl/dbscan_point_clustering.sv
// Operation: points load into the coordinate memory; after the last point the region
// queries run, each a scan of all N stored points through the coordinate memory
// read port and a two-stage distance unit; then one label is emitted per point and
// the state is cleared.
// Throughput: one point per cycle while loading; one set at a time.
// Reset: synchronous, active high; clears counters and flags, sets radius 8 and min points 3.
// ----------------------------------------------------------------------------
// dbscan_point_clustering
// DBSCAN clustering of up to MAX_POINTS 2-D points held in on-chip memory.
// ----------------------------------------------------------------------------
`include "dbscan_point_clustering_defines.svh"
module dbscan_point_clustering (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dbs_pkg::COORD_BITS-1:0]   req_coord_x,
   input  logic [dbs_pkg::COORD_BITS-1:0]   req_coord_y,
   input  logic                             req_last_point,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [5:0]                       rsp_point_index,
   output logic [6:0]                       rsp_cluster_label,
   output logic                             rsp_last_label,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [2:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   localparam int IB = dbs_pkg::IDX_BITS;
   localparam int CB = dbs_pkg::CNT_BITS;
   localparam int LB = dbs_pkg::LBL_BITS;

   dbs_pkg::state_type state_ff, state_in;
   logic [15:0] radius_ff, radius_in;
   logic [6:0] minpts_ff, minpts_in;
   logic [CB-1:0] count_ff, count_in;
   logic [LB-1:0] clus_ff, clus_in;
   logic [IB-1:0] p_ff, p_in;          // outer scan point
   logic [IB-1:0] q_ff, q_in;          // point under query
   logic [CB-1:0] scan_ff, scan_in;    // issued reads
   logic [CB-1:0] chk_ff, chk_in;      // tested results
   logic [CB-1:0] ncnt_ff, ncnt_in;
   logic [CB-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [dbs_pkg::MAX_POINTS-1:0] vis_ff, vis_in, qd_ff, qd_in, lset_ff, lset_in;
   logic [dbs_pkg::COORD_BITS-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [IB-1:0] pipe_idx_ff [2];
   logic [1:0] pipe_v_ff;
   logic pipe_v_in;
   logic [IB-1:0] pipe_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [5:0] rsp_idx_ff, rsp_idx_in;
   logic [6:0] rsp_lbl_ff, rsp_lbl_in;
   logic rsp_last_ff, rsp_last_in;

   // Label memory and seed queue memory.
   logic [LB-1:0] lmem [dbs_pkg::MAX_POINTS];
   logic [IB-1:0] qmem [dbs_pkg::MAX_POINTS];
   logic lwr_en, qwr_en;
   logic [IB-1:0] lwr_addr, lrd_addr, qwr_addr, qrd_addr, qwr_data;
   logic [LB-1:0] lrd_ff;
   logic [IB-1:0] qrd_ff;

   dbs_pkg::pt_req_type pt_req;
   logic [dbs_pkg::COORD_BITS-1:0] rd_x, rd_y;
   logic near;
   logic wr_cfg, in_xfer, out_xfer;

   dbs_point_store u_store (.clock(clock), .req(pt_req), .rd_x(rd_x), .rd_y(rd_y));
   dbs_dist u_dist (.clock(clock), .ax(qx_ff), .ay(qy_ff), .bx(rd_x), .by(rd_y),
                    .radius(radius_ff), .near(near));

   assign csr_pready = 1'b1;
   assign wr_cfg = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      case (csr_paddr[2])
         dbs_pkg::REG_RADIUS[0]: csr_prdata = {16'd0, radius_ff};
         default:                csr_prdata = {25'd0, minpts_ff};
      endcase
   end

   assign req_stall = (state_ff != dbs_pkg::ST_LOAD);
   assign in_xfer = req_valid && !req_stall;
   assign out_xfer = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_point_index = rsp_idx_ff;
   assign rsp_cluster_label = rsp_lbl_ff;
   assign rsp_last_label = rsp_last_ff;

   // Pipeline result tag: index of the point whose distance is now at the output.
   logic res_v;
   logic [IB-1:0] res_idx;
   assign res_v = pipe_v_ff[1];
   assign res_idx = pipe_idx_ff[1];

   always_ff @(posedge clock) begin
      if (lwr_en) lmem[lwr_addr] <= clus_ff;
      if (qwr_en) qmem[qwr_addr] <= qwr_data;
      lrd_ff <= lmem[lrd_addr];
      qrd_ff <= qmem[qrd_addr];
      pipe_idx_ff[0] <= pipe_idx_in;
      pipe_idx_ff[1] <= pipe_idx_ff[0];
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_lbl_ff <= rsp_lbl_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbs_pkg::ST_LOAD;
         radius_ff <= 16'd8;
         minpts_ff <= 7'd3;
         count_ff <= '0;
         clus_ff <= LB'(1);
         p_ff <= '0; q_ff <= '0;
         scan_ff <= '0; chk_ff <= '0; ncnt_ff <= '0;
         head_ff <= '0; tail_ff <= '0;
         vis_ff <= '0; qd_ff <= '0; lset_ff <= '0;
         pipe_v_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         radius_ff <= radius_in;
         minpts_ff <= minpts_in;
         count_ff <= count_in;
         clus_ff <= clus_in;
         p_ff <= p_in; q_ff <= q_in;
         scan_ff <= scan_in; chk_ff <= chk_in; ncnt_ff <= ncnt_in;
         head_ff <= head_in; tail_ff <= tail_in;
         vis_ff <= vis_in; qd_ff <= qd_in; lset_ff <= lset_in;
         pipe_v_ff <= {pipe_v_ff[0], pipe_v_in};
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      radius_in = radius_ff;
      minpts_in = minpts_ff;
      if (wr_cfg && csr_paddr == {dbs_pkg::REG_RADIUS[0], 2'b00}) radius_in = csr_pwdata[15:0];
      if (wr_cfg && csr_paddr == {dbs_pkg::REG_MIN_POINTS[0], 2'b00}) minpts_in = csr_pwdata[6:0];
      count_in = count_ff; clus_in = clus_ff;
      p_in = p_ff; q_in = q_ff;
      scan_in = scan_ff; chk_in = chk_ff; ncnt_in = ncnt_ff;
      head_in = head_ff; tail_in = tail_ff;
      vis_in = vis_ff; qd_in = qd_ff; lset_in = lset_ff;
      qx_in = qx_ff; qy_in = qy_ff;
      pipe_v_in = 1'b0;
      pipe_idx_in = scan_ff[IB-1:0];
      pt_req.wr_en = 1'b0;
      pt_req.wr_addr = count_ff[IB-1:0];
      pt_req.wr_x = req_coord_x;
      pt_req.wr_y = req_coord_y;
      pt_req.rd_addr = scan_ff[IB-1:0];
      lwr_en = 1'b0; lwr_addr = q_ff;
      lrd_addr = p_ff;
      qwr_en = 1'b0; qwr_addr = tail_ff[IB-1:0]; qwr_data = res_idx;
      qrd_addr = head_ff[IB-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in = rsp_idx_ff; rsp_lbl_in = rsp_lbl_ff; rsp_last_in = rsp_last_ff;

      case (state_ff)
         dbs_pkg::ST_LOAD: begin
            if (in_xfer) begin
               if (count_ff < CB'(dbs_pkg::MAX_POINTS)) begin
                  pt_req.wr_en = 1'b1;
                  count_in = count_ff + CB'(1);
               end
               if (req_last_point) begin
                  p_in = '0;
                  state_in = dbs_pkg::ST_SCAN_P;
               end
            end
         end
         dbs_pkg::ST_SCAN_P: begin
            // Pick the next unvisited outer point, or move on to output.
            if (CB'(p_ff) >= count_ff || count_ff == '0) begin
               p_in = '0;
               state_in = dbs_pkg::ST_EMIT;
            end else if (vis_ff[p_ff]) begin
               if (CB'(p_ff) + CB'(1) >= count_ff) begin
                  p_in = '0;
                  state_in = dbs_pkg::ST_EMIT;
               end else begin
                  p_in = p_ff + IB'(1);
               end
            end else begin
               vis_in[p_ff] = 1'b1;
               q_in = p_ff;
               pt_req.rd_addr = p_ff;
               scan_in = '0; chk_in = '0; ncnt_in = '0;
               head_in = '0; tail_in = '0;
               state_in = dbs_pkg::ST_CNT_WAIT;
            end
         end
         dbs_pkg::ST_CNT_WAIT: begin
            // Query point coordinates arrive from the store.
            qx_in = rd_x; qy_in = rd_y;
            state_in = dbs_pkg::ST_CNT;
         end
         dbs_pkg::ST_CNT: begin
            if (scan_ff < count_ff) begin
               pipe_v_in = 1'b1;
               scan_in = scan_ff + CB'(1);
            end
            if (res_v) begin
               chk_in = chk_ff + CB'(1);
               if (near) ncnt_in = ncnt_ff + CB'(1);
            end
            if (res_v && chk_ff + CB'(1) == count_ff) begin
               scan_in = '0; chk_in = '0;
               if ((7'(ncnt_ff) + 7'(near)) >= minpts_ff) begin
                  if (q_ff == p_ff) begin
                     lwr_en = 1'b1;
                     lset_in[q_ff] = 1'b1;
                  end
                  state_in = dbs_pkg::ST_ENQ;
               end else if (q_ff == p_ff) begin
                  state_in = dbs_pkg::ST_SCAN_P;
               end else begin
                  state_in = dbs_pkg::ST_POP;
               end
            end
         end
         dbs_pkg::ST_ENQ: begin
            if (scan_ff < count_ff) begin
               pipe_v_in = 1'b1;
               scan_in = scan_ff + CB'(1);
            end
            if (res_v) begin
               chk_in = chk_ff + CB'(1);
               if (near && !qd_ff[res_idx] && tail_ff < CB'(dbs_pkg::MAX_POINTS)) begin
                  qd_in[res_idx] = 1'b1;
                  qwr_en = 1'b1;
                  tail_in = tail_ff + CB'(1);
               end
               if (chk_ff + CB'(1) == count_ff) state_in = dbs_pkg::ST_POP;
            end
         end
         dbs_pkg::ST_POP: begin
            // Take the next seed, or close the cluster when the queue is empty.
            if (head_ff == tail_in) begin
               clus_in = clus_ff + LB'(1);
               if (CB'(p_ff) + CB'(1) >= count_ff) begin
                  p_in = '0;
                  state_in = dbs_pkg::ST_EMIT;
               end else begin
                  p_in = p_ff + IB'(1);
                  state_in = dbs_pkg::ST_SCAN_P;
               end
            end else begin
               state_in = dbs_pkg::ST_POP_WAIT;
            end
         end
         dbs_pkg::ST_POP_WAIT: begin
            head_in = head_ff + CB'(1);
            q_in = qrd_ff;
            if (!lset_ff[qrd_ff]) begin
               lwr_en = 1'b1; lwr_addr = qrd_ff;
               lset_in[qrd_ff] = 1'b1;
            end
            if (!vis_ff[qrd_ff]) begin
               vis_in[qrd_ff] = 1'b1;
               pt_req.rd_addr = qrd_ff;
               scan_in = '0; chk_in = '0; ncnt_in = '0;
               state_in = dbs_pkg::ST_CNT_WAIT;
            end else begin
               state_in = dbs_pkg::ST_POP;
            end
         end
         dbs_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = dbs_pkg::ST_EMIT_WAIT;
         end
         dbs_pkg::ST_EMIT_WAIT: begin
            // Label read is back; load the output register, drop unset labels to noise.
            rsp_valid_in = 1'b1;
            rsp_idx_in = 6'(p_ff);
            rsp_lbl_in = lset_ff[p_ff] ? lrd_ff : 7'd0;
            rsp_last_in = (CB'(p_ff) + CB'(1) == count_ff);
            if (CB'(p_ff) + CB'(1) == count_ff) begin
               state_in = dbs_pkg::ST_CLEAR;
            end else begin
               p_in = p_ff + IB'(1);
               state_in = dbs_pkg::ST_EMIT;
            end
         end
         dbs_pkg::ST_CLEAR: begin
            count_in = '0; clus_in = LB'(1);
            vis_in = '0; qd_in = '0; lset_in = '0;
            p_in = '0;
            state_in = dbs_pkg::ST_LOAD;
         end
         default: state_in = dbs_pkg::ST_LOAD;
      endcase
   end

   `DBS_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != dbs_pkg::ST_LOAD, !in_xfer, "input transfer while clustering")
   `DBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_idx_ff), "stalled result changed")
   `DBS_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, head_ff <= tail_ff, "seed queue head passed tail")
endmodule

>>> tb/dbscan_label_checker.sv
// ----------------------------------------------------------------------------
// dbscan_label_checker
// Watches point transfers into the clustering block, predicts the label of
// every point of a set when its last point arrives, and compares each label
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dbscan_label_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_coord_x,
   input  logic [15:0] req_coord_y,
   input  logic        req_last_point,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_point_index,
   input  logic [6:0]  rsp_cluster_label,
   input  logic        rsp_last_label,
   input  logic        cfg_we,
   input  logic        cfg_sel,
   input  logic [15:0] cfg_value,
   output int          pending_labels,
   output int          error_count
);
   typedef struct packed {
      logic [5:0] idx;
      logic [6:0] lbl;
      logic       last;
   } label_type;

   label_type         label_fifo[$];
   logic signed [16:0] pt_x[64];
   logic signed [16:0] pt_y[64];
   int                n_pts;
   logic [15:0]       eps;
   logic [6:0]        core_min;

   assign pending_labels = label_fifo.size();

   function automatic bit close_pair(int a, int b);
      longint dx, dy, r;
      dx = pt_x[a] - pt_x[b];
      dy = pt_y[a] - pt_y[b];
      r  = eps;
      return dx * dx + dy * dy <= r * r;
   endfunction

   function automatic int density(int p);
      int c;
      c = 0;
      for (int i = 0; i < n_pts; i++) if (close_pair(p, i)) c++;
      return c;
   endfunction

   // Run breadth-first cluster growth over the stored set and queue labels.
   task automatic predict_labels();
      bit        seen[64];
      bit        queued[64];
      int        lbl[64];
      int        seeds[$];
      int        cl, q;
      label_type e;
      cl = 1;
      for (int i = 0; i < 64; i++) begin
         seen[i] = 0; queued[i] = 0; lbl[i] = 0;
      end
      for (int p = 0; p < n_pts; p++) begin
         if (seen[p]) continue;
         seen[p] = 1;
         if (density(p) < core_min) continue;
         lbl[p] = cl;
         seeds.delete();
         for (int i = 0; i < n_pts; i++)
            if (close_pair(p, i) && !queued[i]) begin
               queued[i] = 1; seeds = {seeds, i};
            end
         while (seeds.size() > 0) begin
            q = seeds.pop_front();
            if (!seen[q]) begin
               seen[q] = 1;
               if (density(q) >= core_min)
                  for (int i = 0; i < n_pts; i++)
                     if (close_pair(q, i) && !queued[i]) begin
                        queued[i] = 1; seeds = {seeds, i};
                     end
            end
            if (lbl[q] == 0) lbl[q] = cl;
         end
         cl++;
      end
      for (int i = 0; i < n_pts; i++) begin
         e.idx = 6'(i); e.lbl = 7'(lbl[i]); e.last = (i == n_pts - 1);
         label_fifo = {label_fifo, e};
      end
      n_pts = 0;
   endtask

   always @(posedge clock) begin
      label_type e;
      int        errs;
      errs = 0;
      if (reset) begin
         n_pts = 0; eps <= 16'd8; core_min <= 7'd3;
         label_fifo.delete(); error_count <= 0;
      end else begin
         if (cfg_we) begin
            if (cfg_sel) core_min <= cfg_value[6:0];
            else eps <= cfg_value;
         end
         if (rsp_valid && !rsp_stall) begin
            if (label_fifo.size() == 0) begin
               $error("label transfer with nothing expected: index %0d", rsp_point_index);
               errs++;
            end else begin
               e = label_fifo.pop_front();
               if (rsp_point_index !== e.idx) begin
                  $error("point_index expected %0d got %0d", e.idx, rsp_point_index);
                  errs++;
               end
               if (rsp_cluster_label !== e.lbl) begin
                  $error("cluster_label expected %0d got %0d", e.lbl, rsp_cluster_label);
                  errs++;
               end
               if (rsp_last_label !== e.last) begin
                  $error("last_label expected %0d got %0d", e.last, rsp_last_label);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (n_pts < 64) begin
               pt_x[n_pts] = $signed(req_coord_x);
               pt_y[n_pts] = $signed(req_coord_y);
               n_pts = n_pts + 1;
            end
            if (req_last_point) predict_labels();
         end
         if (errs > 0) error_count <= error_count + errs;
      end
   end
endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives point sets and register writes into the clustering block under
// random idling and stalling; a checker beside the block predicts labels.
// ----------------------------------------------------------------------------
module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [15:0] req_coord_x = 0;
   logic [15:0] req_coord_y = 0;
   logic        req_last_point = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [5:0]  rsp_point_index;
   logic [6:0]  rsp_cluster_label;
   logic        rsp_last_label;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          pending_labels;
   int          error_count;

   // Idle percentages for sender and receiver; hold_phase starts a long stall.
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_phase = 0;
   int          hold_cycles = 0;

   always #6 clock = ~clock;

   dbscan_point_clustering u_dut (.*);

   dbscan_label_checker u_chk (
      .clock, .reset, .req_valid, .req_stall, .req_coord_x, .req_coord_y,
      .req_last_point, .rsp_valid, .rsp_stall, .rsp_point_index,
      .rsp_cluster_label, .rsp_last_label,
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_sel(csr_paddr[2]), .cfg_value(csr_pwdata[15:0]),
      .pending_labels, .error_count);

   // Receiver: stall at random, or hold off for a counted stretch.
   always @(posedge clock) begin
      if (hold_phase && hold_cycles < 3000) begin
         rsp_stall   <= 1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Write one register through a setup and an access phase.
   task automatic write_reg(logic [1:0] sel, logic [31:0] val);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= {sel[0], 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   // Offer one point and hold it until the transfer happens.
   task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_coord_x <= x; req_coord_y <= y; req_last_point <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait for every predicted label, then let the block finish its clear.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_labels > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Send a random set; points bunch around a few centers so clusters form.
   task automatic send_set(int n, int spread);
      int cx, cy;
      cx = $urandom; cy = $urandom;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0) begin
            cx = $urandom; cy = $urandom;
         end
         send_point(16'(cx + $urandom_range(2 * spread) - spread),
                    16'(cy + $urandom_range(2 * spread) - spread), i == n - 1);
      end
   endtask

   int sent;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: coordinate extremes, duplicates, border and noise points.
      send_point(16'h8000, 16'h8000, 0);
      send_point(16'h7fff, 16'h7fff, 0);
      send_point(16'h8000, 16'h7fff, 0);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'h0003, 16'h0004, 0);
      send_point(16'h0008, 16'h0000, 0);
      send_point(16'h0010, 16'h0000, 1);
      drain();
      // Zero radius with min_points 1: every distinct point its own cluster, duplicates share one.
      write_reg(dbs_pkg::REG_RADIUS, 0);
      write_reg(dbs_pkg::REG_MIN_POINTS, 1);
      send_point(16'h0001, 16'hffff, 0);
      send_point(16'h0001, 16'hffff, 0);
      send_point(16'hffff, 16'h0001, 1);
      drain();
      // Full radius, min_points 0 then above the set size.
      write_reg(dbs_pkg::REG_RADIUS, 65535);
      write_reg(dbs_pkg::REG_MIN_POINTS, 0);
      send_point(16'h8000, 16'h0000, 0);
      send_point(16'h7fff, 16'h0000, 1);
      drain();
      write_reg(dbs_pkg::REG_MIN_POINTS, 64);
      send_point(16'h1234, 16'h5678, 1);
      drain();
      // Overfull set: points beyond the store are dropped.
      write_reg(dbs_pkg::REG_RADIUS, 8);
      write_reg(dbs_pkg::REG_MIN_POINTS, 3);
      send_set(70, 6);
      drain();

      // Random phases over idling patterns and register settings.
      sent = 0;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         write_reg(dbs_pkg::REG_RADIUS, (ph == 7) ? 65535 : $urandom_range(2, 40));
         write_reg(dbs_pkg::REG_MIN_POINTS, (ph == 6) ? 64 : $urandom_range(1, 5));
         // Hold off the receiver while points keep coming so the block backs up.
         if (ph == 2) hold_phase = 1;
         while (sent < 30 * (ph + 1)) begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
            send_set(n, $urandom_range(1, 30));
            sent += n;
         end
         drain();
      end

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #400000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
